FILE: sv/qcs_pkg.sv
// qcs_pkg: shared constants and command/status types for the quadrature
// count and speed block. No dependencies.
package qcs_pkg;

  // Default position counter width
  localparam int COUNT_WIDTH_DEF = 32;

  // Field widths fixed by the interface
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int ELAPSED_W   = 32;
  localparam int SPEED_W     = 32;
  localparam int POS_OUT_W   = 32;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] MIN_INTERVAL_RST = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RATE_SCALE_RST   = 16'd1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE   = 1'd1;

  // Input bit positions inside in_tdata
  localparam int IN_A_BIT     = 0;
  localparam int IN_B_BIT     = 1;
  localparam int IN_TICK_BIT  = 2;
  localparam int IN_REQ_BIT   = 3;
  localparam int IN_CLR_BIT   = 4;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // transaction accepted: update count state
    logic load_fast;  // load output register, no speed
    logic mul;        // register delta * scale, arm divider
    logic div;        // one restoring divide step
    logic load_spd;   // load output register with speed result
  } qcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;   // current sample asks for a speed that must be computed
    logic div_last;   // final divide step in progress
  } qcs_sts_t;

endpackage

FILE: sv/qcs_ctrl.sv
// qcs_ctrl: sequencing FSM for the quadrature count and speed block.
// Owns the handshakes and the output valid flag. Depends on qcs_pkg.
module qcs_ctrl import qcs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  qcs_sts_t sts,
  output qcs_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } qcs_state_t;

  qcs_state_t state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       out_free;
  logic       acc;

  assign out_free   = !ovld_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && out_free;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    ovld_nxt  = ovld_r && !out_tready;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd.take = 1'b1;
          if (sts.need_div) begin
            state_nxt = ST_MUL;
          end else begin
            cmd.load_fast = 1'b1;
            ovld_nxt      = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_spd = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && sts.need_div) |=> (state_r == ST_MUL))
    else $error("speed request did not start the multiply");

  a_last_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_last) |=> (state_r == ST_FIN))
    else $error("divider overran its step count");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (ovld_r && state_r == ST_IDLE))
    else $error("speed result not presented");

endmodule

FILE: sv/qcs_dp.sv
// qcs_dp: position counter, elapsed timer, configuration registers,
// multiplier and restoring divider. Driven by qcs_ctrl; depends on qcs_pkg.
module qcs_dp import qcs_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  qcs_cmd_t              cmd,
  output qcs_sts_t              sts,
  input  logic [IN_TDATA_W-1:0] in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [POS_OUT_W-1:0]  position,
  output logic [SPEED_W-1:0]    speed,
  output logic                  speed_valid
);

  localparam int PW   = COUNT_WIDTH + CFG_DATA_W;   // product / quotient width
  localparam int QXW  = (PW > 33) ? PW : 33;        // room for saturation limits
  localparam int CNTW = $clog2(PW);

  // count state
  logic                   prev_a_r, primed_r;
  logic [COUNT_WIDTH-1:0] pos_r, pos_nxt, pos_e;
  logic [COUNT_WIDTH-1:0] last_r;
  logic [ELAPSED_W-1:0]   el_r, el_t;
  logic [CFG_DATA_W-1:0]  min_r, scale_r, need;

  // divide datapath
  logic                   neg_r;
  logic [COUNT_WIDTH-1:0] mag_r, delta;
  logic [ELAPSED_W-1:0]   dvsr_r;
  logic [PW-1:0]          quo_r;
  logic [ELAPSED_W-1:0]   rem_r;
  logic [CNTW-1:0]        cnt_r;
  logic [ELAPSED_W:0]     shifted, trial;
  logic [QXW-1:0]         qx;
  logic [SPEED_W-1:0]     qsat, spd_res;

  // output register
  logic [POS_OUT_W-1:0]   opos_r;
  logic [SPEED_W-1:0]     ospd_r;
  logic                   ovalid_r;

  logic a, b, tick, req, clr, edge_hit;

  assign a    = in_data[IN_A_BIT];
  assign b    = in_data[IN_B_BIT];
  assign tick = in_data[IN_TICK_BIT];
  assign req  = in_data[IN_REQ_BIT];
  assign clr  = in_data[IN_CLR_BIT];

  always_comb begin
    // edge, then tick, then speed check, then clear
    edge_hit = primed_r && (a != prev_a_r);
    if (edge_hit) begin
      pos_e = (b == a) ? pos_r + COUNT_WIDTH'(1) : pos_r - COUNT_WIDTH'(1);
    end else begin
      pos_e = pos_r;
    end
    el_t = (tick && (el_r != '1)) ? el_r + ELAPSED_W'(1) : el_r;
    need = (min_r == '0) ? CFG_DATA_W'(1) : min_r;
    sts.need_div = req && (el_t >= ELAPSED_W'(need));
    sts.div_last = (cnt_r == CNTW'(PW - 1));
    pos_nxt = clr ? '0 : pos_e;
    delta   = pos_e - last_r;
  end

  // restoring divide step
  always_comb begin
    shifted = {rem_r, quo_r[PW-1]};
    trial   = shifted - {1'b0, dvsr_r};
  end

  // saturate the magnitude and apply the sign
  always_comb begin
    qx = QXW'(quo_r);
    if (neg_r) begin
      qsat    = (qx > QXW'(33'h0_8000_0000)) ? 32'h8000_0000 : qx[SPEED_W-1:0];
      spd_res = -qsat;
    end else begin
      qsat    = (qx > QXW'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : qx[SPEED_W-1:0];
      spd_res = qsat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b0;
      primed_r <= 1'b0;
      pos_r    <= '0;
      last_r   <= '0;
      el_r     <= '0;
      min_r    <= MIN_INTERVAL_RST;
      scale_r  <= RATE_SCALE_RST;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MIN_INTERVAL: min_r   <= cfg_wdata;
          REG_RATE_SCALE:   scale_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.take) begin
        prev_a_r <= a;
        primed_r <= 1'b1;
        pos_r    <= pos_nxt;
        if (sts.need_div) begin
          last_r <= pos_e;
          el_r   <= '0;
        end else begin
          el_r   <= el_t;
        end
      end
      if (cmd.mul) begin
        cnt_r <= '0;
      end else if (cmd.div) begin
        cnt_r <= cnt_r + CNTW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take && sts.need_div) begin
      neg_r  <= delta[COUNT_WIDTH-1];
      mag_r  <= delta[COUNT_WIDTH-1] ? -delta : delta;
      dvsr_r <= el_t;
    end
    if (cmd.mul) begin
      quo_r <= PW'(mag_r) * PW'(scale_r);
      rem_r <= '0;
    end else if (cmd.div) begin
      if (!trial[ELAPSED_W]) begin
        rem_r <= trial[ELAPSED_W-1:0];
        quo_r <= {quo_r[PW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[ELAPSED_W-1:0];
        quo_r <= {quo_r[PW-2:0], 1'b0};
      end
    end
    if (cmd.load_fast) begin
      opos_r   <= POS_OUT_W'($signed(pos_nxt));
      ospd_r   <= '0;
      ovalid_r <= 1'b0;
    end else if (cmd.load_spd) begin
      opos_r   <= POS_OUT_W'($signed(pos_r));
      ospd_r   <= spd_res;
      ovalid_r <= 1'b1;
    end
  end

  assign position    = opos_r;
  assign speed       = ospd_r;
  assign speed_valid = ovalid_r;

  a_dvsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (dvsr_r != '0))
    else $error("divide by zero elapsed");

endmodule

FILE: sv/quadrature_count_and_speed.sv
// quadrature_count_and_speed: top level, x2 quadrature decoder with speed
// estimate. Instantiates qcs_ctrl and qcs_dp; depends on qcs_pkg.
//
// Usage:
//  - in_*  : one transaction per encoder sample (A, B, ms strobe, speed request,
//            count clear). Every change of A after the first sample steps the
//            position count up (B equals new A) or down; clear wins.
//  - out_* : exactly one result per input transaction, in order: position,
//            speed and a speed-valid flag on out_tuser.
//  - cfg_* : register writes (0 min_interval_ms, 1 rate_scale); always ready,
//            to be written only while the block is idle.
// Throughput: one sample per cycle when no speed is computed and out_* is not
//  stalled; the result shows on out_* the cycle after acceptance.
// A speed computation holds the input: accept, one multiply, one restoring
//  divide step per quotient bit and one to saturate and load once the output
//  register is free. No sample is accepted meanwhile.
// Reset (synchronous, rst_n low): count, reference count, elapsed time and
//  priming flag clear; registers return to 100 ms and scale 1000.
// Receiver stall: the output register holds its result; one more sample is
//  taken only in the cycle the pending result is taken.
module quadrature_count_and_speed import qcs_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input samples
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] a_level, [1] b_level, [2] ms_tick, [3] speed_request, [4] clear_count
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] position, [63:32] speed
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] speed_valid
  output logic                   out_tuser,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  qcs_cmd_t             cmd;
  qcs_sts_t             sts;
  logic [POS_OUT_W-1:0] position;
  logic [SPEED_W-1:0]   speed;

  // register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  qcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  qcs_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_tdata),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .position    (position),
    .speed       (speed),
    .speed_valid (out_tuser)
  );

  assign out_tdata = {speed, position};

endmodule
